// ===== hdl/cswg_pkg.sv =====
// Shared constants, register codes and window coefficient tables for the window generator.
`timescale 1ns / 1ps

package cswg_pkg;

   // Port widths fixed by the item and register formats.
   localparam int SAMPLE_INDEX_WIDTH = 16;
   localparam int WINDOW_VALUE_WIDTH = 19;
   localparam int CSR_INDEX_WIDTH    = 1;
   localparam int CSR_DATA_WIDTH     = 32;
   localparam int KIND_WIDTH         = 2;
   localparam int PHASE_WIDTH        = 32;

   // Parameter defaults for the top level.
   localparam int INDEX_BITS_DEFAULT      = 16;
   localparam int COS_TABLE_DEPTH_DEFAULT = 1024;

   // Register indexes on the write port.
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_WINDOW_KIND = 1'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_PHASE_STEP  = 1'd1;

   // Window kind codes. The unused code behaves as Hann.
   localparam logic [KIND_WIDTH-1:0] KIND_HANN = 2'd0;
   localparam logic [KIND_WIDTH-1:0] KIND_BH4  = 2'd1;
   localparam logic [KIND_WIDTH-1:0] KIND_BH7  = 2'd2;

   // Register reset values.
   localparam logic [KIND_WIDTH-1:0]  WINDOW_KIND_RESET = KIND_HANN;
   localparam logic [PHASE_WIDTH-1:0] PHASE_STEP_RESET  = 32'd4198404;

   // Number of cosine terms beyond the constant term (seven-term window).
   localparam int NUM_COS_TERMS = 6;

   // Fixed-point constants.
   localparam logic signed [63:0] Q30_ONE     = 64'sd1073741824;
   localparam logic signed [63:0] PI_HALF_Q30 = 64'sd1686629713;
   localparam logic signed [63:0] ROUND_HALF  = 64'sd2199023255552;
   localparam logic [WINDOW_VALUE_WIDTH-1:0] OUT_ONE = 19'd262144;

   // Q0.30 coefficient of a given term for a given window kind.
   function automatic logic signed [31:0] window_coef(input logic [KIND_WIDTH-1:0] kind,
                                                      input logic [2:0] term);
      logic signed [31:0] coef;
      coef = 32'sd0;
      case (kind)
         KIND_BH4: begin
            case (term)
               3'd0:    coef = 32'sd385204879;
               3'd1:    coef = -32'sd524297395;
               3'd2:    coef = 32'sd151698245;
               3'd3:    coef = -32'sd12541305;
               default: coef = 32'sd0;
            endcase
         end
         KIND_BH7: begin
            case (term)
               3'd0:    coef = 32'sd291220645;
               3'd1:    coef = -32'sd465407609;
               3'd2:    coef = 32'sd234080141;
               3'd3:    coef = -32'sd70636475;
               3'd4:    coef = 32'sd11555467;
               3'd5:    coef = -32'sd826795;
               3'd6:    coef = 32'sd14690;
               default: coef = 32'sd0;
            endcase
         end
         default: begin
            case (term)
               3'd0:    coef = 32'sd536870912;
               3'd1:    coef = -32'sd536870912;
               default: coef = 32'sd0;
            endcase
         end
      endcase
      return coef;
   endfunction

endpackage

// ===== hdl/cswg_cos_rom.sv =====
// Quarter-wave cosine table with a registered read port.
`timescale 1ns / 1ps

module cswg_cos_rom #(
   parameter int COS_TABLE_DEPTH = cswg_pkg::COS_TABLE_DEPTH_DEFAULT
) (
   input  logic                                  clock,
   input  logic                                  rd_en,
   input  logic [$clog2(COS_TABLE_DEPTH+1)-1:0]  rd_addr,
   output logic [30:0]                           rd_data
);
   import cswg_pkg::*;

   typedef logic [30:0] cos_rom_type [COS_TABLE_DEPTH+1];

   // The table angle advances by pi/2 over the depth; the whole and fractional parts
   // of that step let each angle be formed exactly by accumulation.
   localparam logic signed [63:0] DEPTH_WIDE  = 64'(COS_TABLE_DEPTH);
   localparam logic signed [63:0] X_STEP_QUOT = PI_HALF_Q30 / DEPTH_WIDE;
   localparam logic signed [63:0] X_STEP_REM  = PI_HALF_Q30 % DEPTH_WIDE;

   // Reciprocals of the Horner denominators (2n)(2n-1), for n from one to ten. With a
   // 42-bit shift the truncated quotient is exact for every numerator below 2^32.
   localparam int RECIP_SHIFT = 42;
   localparam logic [63:0] HORNER_RECIP [1:10] = '{
      (64'd1 << RECIP_SHIFT) / 64'd2   + 64'd1,
      (64'd1 << RECIP_SHIFT) / 64'd12  + 64'd1,
      (64'd1 << RECIP_SHIFT) / 64'd30  + 64'd1,
      (64'd1 << RECIP_SHIFT) / 64'd56  + 64'd1,
      (64'd1 << RECIP_SHIFT) / 64'd90  + 64'd1,
      (64'd1 << RECIP_SHIFT) / 64'd132 + 64'd1,
      (64'd1 << RECIP_SHIFT) / 64'd182 + 64'd1,
      (64'd1 << RECIP_SHIFT) / 64'd240 + 64'd1,
      (64'd1 << RECIP_SHIFT) / 64'd306 + 64'd1,
      (64'd1 << RECIP_SHIFT) / 64'd380 + 64'd1
   };

   // Truncated quotient of a nonnegative Q60 product by Q30 one times a Horner
   // denominator: the Q30 part is a shift, the rest a reciprocal multiplication.
   function automatic logic signed [63:0] horner_quot(input logic signed [63:0] num,
                                                      input logic [63:0]        recip);
      logic [127:0] prod;
      prod = 128'(num >>> 30) * 128'(recip);
      return $signed(prod[RECIP_SHIFT+63:RECIP_SHIFT]);
   endfunction

   // Builds every entry from a ten-step Horner series of the cosine in Q30.
   function automatic cos_rom_type build_rom();
      cos_rom_type        rom;
      logic signed [63:0] x_quot;
      logic signed [63:0] x_rem;
      logic signed [63:0] x2;
      logic signed [63:0] acc;
      int                 j;
      int                 n;
      x_quot = 64'sd0;
      x_rem  = 64'sd0;
      for (j = 0; j <= COS_TABLE_DEPTH; j++) begin
         x2  = (x_quot * x_quot + 64'sd536870912) >>> 30;
         acc = Q30_ONE;
         for (n = 10; n >= 1; n--) begin
            acc = Q30_ONE - horner_quot(acc * x2, HORNER_RECIP[n]);
         end
         if (acc < 64'sd0) begin
            acc = 64'sd0;
         end
         if (acc > Q30_ONE) begin
            acc = Q30_ONE;
         end
         rom[j] = acc[30:0];
         x_quot = x_quot + X_STEP_QUOT;
         x_rem  = x_rem + X_STEP_REM;
         if (x_rem >= DEPTH_WIDE) begin
            x_rem  = x_rem - DEPTH_WIDE;
            x_quot = x_quot + 64'sd1;
         end
      end
      return rom;
   endfunction

   localparam cos_rom_type COS_ROM = build_rom();

   logic [30:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= COS_ROM[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== hdl/cosine_sum_window_generator.sv =====
// Top level of the cosine-sum window coefficient generator (Hann and Blackman-Harris).
`timescale 1ns / 1ps
// Nine register stages, from the index register to the rounded result register, which
// drives rsp_valid; the clock edge that accepts a transfer loads the index register.
// Throughput: one transfer per cycle unless a waiting result stalls the pipeline; the
// per-term cosine tables are read in parallel, and bubbles close up whenever the result waits.
// Reset (synchronous, active high) empties the pipeline and returns window_kind to Hann
// and phase_step to 4198404; the cosine tables are constants and need no clearing.

module cosine_sum_window_generator #(
   parameter int INDEX_BITS      = cswg_pkg::INDEX_BITS_DEFAULT,
   parameter int COS_TABLE_DEPTH = cswg_pkg::COS_TABLE_DEPTH_DEFAULT
) (
   input  logic                                      clock,
   input  logic                                      reset,
   input  logic                                      req_valid,
   output logic                                      req_ready,
   input  logic [cswg_pkg::SAMPLE_INDEX_WIDTH-1:0]   req_sample_index,
   output logic                                      rsp_valid,
   input  logic                                      rsp_ready,
   output logic [cswg_pkg::WINDOW_VALUE_WIDTH-1:0]   rsp_window_value,
   input  logic                                      csr_write_enable,
   input  logic [cswg_pkg::CSR_INDEX_WIDTH-1:0]      csr_index,
   input  logic [cswg_pkg::CSR_DATA_WIDTH-1:0]       csr_write_data
);
   import cswg_pkg::*;

   // Only the low INDEX_BITS bits of the index take part, and never more than the port has.
   localparam int IDX_W = (INDEX_BITS < SAMPLE_INDEX_WIDTH) ? INDEX_BITS : SAMPLE_INDEX_WIDTH;
   // Table address width; the table holds COS_TABLE_DEPTH+1 entries.
   localparam int AW = $clog2(COS_TABLE_DEPTH + 1);
   // Width of the product that maps a quadrant remainder onto a table entry.
   localparam int PW = 30 + AW;
   localparam int NUM_STAGES = 9;

   // Stage map:
   //   1 index register       2 base phase (index times step)   3 per-term phases
   //   4 table addresses      5 table read                       6 signed products
   //   7 partial sums         8 full Q60 sum                     9 rounded, clamped result

   // Configuration registers.
   logic [KIND_WIDTH-1:0]  window_kind_ff;
   logic [PHASE_WIDTH-1:0] phase_step_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         window_kind_ff <= WINDOW_KIND_RESET;
         phase_step_ff  <= PHASE_STEP_RESET;
      end else if (csr_write_enable) begin
         case (csr_index)
            CSR_WINDOW_KIND: window_kind_ff <= csr_write_data[KIND_WIDTH-1:0];
            CSR_PHASE_STEP:  phase_step_ff  <= csr_write_data[PHASE_WIDTH-1:0];
            default:         window_kind_ff <= window_kind_ff;
         endcase
      end
   end

   // Pipeline control. A stage loads when it is empty or when the stage after it loads,
   // so a waiting result stalls only the stages that are actually occupied.
   logic [NUM_STAGES:1] valid_ff;
   logic [NUM_STAGES:1] valid_in;
   logic [NUM_STAGES:1] stage_en;

   always_comb begin
      stage_en[NUM_STAGES] = !valid_ff[NUM_STAGES] || rsp_ready;
      for (int s = NUM_STAGES - 1; s >= 1; s--) begin
         stage_en[s] = !valid_ff[s] || stage_en[s+1];
      end
      valid_in[1] = req_valid;
      for (int s = 2; s <= NUM_STAGES; s++) begin
         valid_in[s] = valid_ff[s-1];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         for (int s = 1; s <= NUM_STAGES; s++) begin
            if (stage_en[s]) begin
               valid_ff[s] <= valid_in[s];
            end
         end
      end
   end

   assign req_ready = stage_en[1];
   assign rsp_valid = valid_ff[NUM_STAGES];

   // Payload registers, one set per stage; the cosine lanes carry one entry per term.
   logic [IDX_W-1:0]        idx_ff,  idx_in;
   logic [PHASE_WIDTH-1:0]  base_ff, base_in;
   logic [PHASE_WIDTH-1:0]  phase_ff [NUM_COS_TERMS];
   logic [PHASE_WIDTH-1:0]  phase_in [NUM_COS_TERMS];
   logic [AW-1:0]           addr_ff  [NUM_COS_TERMS];
   logic [AW-1:0]           addr_in  [NUM_COS_TERMS];
   logic [NUM_COS_TERMS-1:0] neg_ff, neg_in;
   logic [NUM_COS_TERMS-1:0] neg_d_ff;
   logic [30:0]             cos_mag  [NUM_COS_TERMS];
   logic signed [63:0]      prod_ff  [NUM_COS_TERMS];
   logic signed [63:0]      prod_in  [NUM_COS_TERMS];
   logic signed [63:0]      part_a_ff, part_a_in;
   logic signed [63:0]      part_b_ff, part_b_in;
   logic signed [63:0]      part_c_ff, part_c_in;
   logic signed [63:0]      sum_ff,    sum_in;
   logic [WINDOW_VALUE_WIDTH-1:0] value_ff, value_in;

   // Stage 1 and 2: the base phase is index times step, modulo one turn.
   logic [IDX_W+PHASE_WIDTH-1:0] base_full;

   assign idx_in    = req_sample_index[IDX_W-1:0];
   assign base_full = (IDX_W+PHASE_WIDTH)'(idx_ff) * (IDX_W+PHASE_WIDTH)'(phase_step_ff);
   assign base_in   = base_full[PHASE_WIDTH-1:0];

   // Stage 3 and 4: term k runs at k times the base phase. The quadrant picks the
   // mirrored entry in odd quadrants and the sign in the middle two quadrants.
   logic [PW-1:0] entry_full [NUM_COS_TERMS];
   logic [AW-1:0] entry      [NUM_COS_TERMS];

   always_comb begin
      for (int k = 0; k < NUM_COS_TERMS; k++) begin
         phase_in[k]   = PHASE_WIDTH'(35'(base_ff) * 35'(k + 1));
         entry_full[k] = PW'(phase_ff[k][29:0]) * PW'(COS_TABLE_DEPTH) + PW'(32'd536870912);
         entry[k]      = entry_full[k][PW-1:30];
         addr_in[k]    = phase_ff[k][30] ? (AW'(COS_TABLE_DEPTH) - entry[k]) : entry[k];
         neg_in[k]     = phase_ff[k][31] ^ phase_ff[k][30];
      end
   end

   // Stage 5: one table per term, read in parallel.
   for (genvar g = 0; g < NUM_COS_TERMS; g++) begin : g_cos_lane
      cswg_cos_rom #(
         .COS_TABLE_DEPTH(COS_TABLE_DEPTH)
      ) u_cos_rom (
         .clock  (clock),
         .rd_en  (stage_en[5]),
         .rd_addr(addr_ff[g]),
         .rd_data(cos_mag[g])
      );
   end

   // Stage 6: each cosine is weighted by its coefficient; the sign of the cosine is
   // folded into the coefficient so that one 32 by 32 multiply remains per lane.
   logic signed [31:0] coef_signed [NUM_COS_TERMS];
   logic signed [31:0] cos_signed  [NUM_COS_TERMS];

   always_comb begin
      for (int k = 0; k < NUM_COS_TERMS; k++) begin
         coef_signed[k] = window_coef(window_kind_ff, 3'(k + 1));
         if (neg_d_ff[k]) begin
            coef_signed[k] = -coef_signed[k];
         end
         cos_signed[k] = $signed({1'b0, cos_mag[k]});
         prod_in[k]    = 64'(coef_signed[k]) * 64'(cos_signed[k]);
      end
   end

   // Stage 7 and 8: the Q60 sum is formed exactly in two levels of adders.
   logic signed [31:0] coef_const;

   assign coef_const = window_coef(window_kind_ff, 3'd0);
   assign part_a_in  = (64'(coef_const) <<< 30) + prod_ff[0] + prod_ff[1];
   assign part_b_in  = prod_ff[2] + prod_ff[3];
   assign part_c_in  = prod_ff[4] + prod_ff[5];
   assign sum_in     = part_a_ff + part_b_ff + part_c_ff;

   // Stage 9: a sum at or below zero gives zero; otherwise round to Q1.18 and
   // saturate at one.
   logic signed [63:0] sum_rounded;
   logic [21:0]        value_wide;

   always_comb begin
      sum_rounded = sum_ff + ROUND_HALF;
      value_wide  = sum_rounded[63:42];
      if (sum_ff <= 64'sd0) begin
         value_in = '0;
      end else if (value_wide > 22'(OUT_ONE)) begin
         value_in = OUT_ONE;
      end else begin
         value_in = value_wide[WINDOW_VALUE_WIDTH-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (stage_en[1]) idx_ff <= idx_in;
      if (stage_en[2]) base_ff <= base_in;
      if (stage_en[3]) phase_ff <= phase_in;
      if (stage_en[4]) begin
         addr_ff <= addr_in;
         neg_ff  <= neg_in;
      end
      if (stage_en[5]) neg_d_ff <= neg_ff;
      if (stage_en[6]) prod_ff <= prod_in;
      if (stage_en[7]) begin
         part_a_ff <= part_a_in;
         part_b_ff <= part_b_in;
         part_c_ff <= part_c_in;
      end
      if (stage_en[8]) sum_ff <= sum_in;
      if (stage_en[9]) value_ff <= value_in;
   end

   assign rsp_window_value = value_ff;

   // An accepted transfer always lands in the first stage.
   assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> valid_ff[1])
      else $error("accepted transfer did not enter the pipeline");

   // An empty pipeline must be able to take a transfer.
   assert property (@(posedge clock) disable iff (reset)
      (valid_ff == '0) |-> req_ready)
      else $error("empty pipeline refused a transfer");

   // While the result waits, a full sum stage behind it holds its value.
   assert property (@(posedge clock) disable iff (reset)
      valid_ff[NUM_STAGES] && !rsp_ready && valid_ff[8] |=> valid_ff[8] && $stable(sum_ff))
      else $error("sum stage changed during a stall");

   // A sum at or below zero produces a zero coefficient.
   assert property (@(posedge clock) disable iff (reset)
      valid_ff[8] && stage_en[9] && (sum_ff <= 64'sd0) |=> rsp_window_value == '0)
      else $error("non-positive sum gave a nonzero coefficient");

endmodule
